/* design/bigint_to_double_rne_core_macros.svh */
// Assertion macros shared by the bigint-to-double RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef BIGINT_TO_DOUBLE_RNE_CORE_MACROS_SVH
`define BIGINT_TO_DOUBLE_RNE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B2D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/b2d_pkg.sv */
// Shared types, constants and helpers for the bigint-to-double converter.
// No dependencies.
`default_nettype none

package b2d_pkg;

	localparam int unsigned DIGIT_W = 64;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned LEAD_W  = 7;
	localparam int unsigned TOTAL_W = 12;

	localparam logic [COUNT_W-1:0] DIGITS_SAT   = 5'd31;
	localparam logic [LEAD_W-1:0]  FULL_DIGIT   = 7'd64;
	localparam logic [10:0]        EXP_ALL_ONES = 11'h7ff;
	localparam logic [10:0]        ROUND_HALF   = 11'h400;
	localparam logic [TOTAL_W-1:0] MAX_BITS     = 12'd1024;
	localparam logic [TOTAL_W-1:0] EXP_OFFSET   = 12'd1022;

	// Accumulated view of one value in progress.
	typedef struct packed {
		logic                 value_sign;
		logic [COUNT_W-1:0]   digits_seen;
		logic [LEAD_W-1:0]    lead_bits;
		logic [DIGIT_W-1:0]   top_window;
		logic                 sticky_flag;
	} b2d_snap_t;

	// Position of the highest set bit plus one; zero for a zero word.
	function automatic logic [LEAD_W-1:0] bit_len(input logic [DIGIT_W-1:0] v);
		logic [LEAD_W-1:0] n;
		n = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			if (v[i]) begin
				n = LEAD_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

/* design/b2d_accum.sv */
// Digit accumulator: bit length, top window, sticky bit and digit count.
// Depends on b2d_pkg.
`default_nettype none

module b2d_accum
	import b2d_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [DIGIT_W-1:0] digit,
	input  wire logic               negative,
	input  wire logic               first_digit,
	input  wire logic               last_digit,
	output logic                    snap_valid,
	output b2d_snap_t               snap,
	output logic                    active
);

	b2d_snap_t         cur_q;
	b2d_snap_t         nxt;
	logic [LEAD_W-1:0] lb_new;
	logic [LEAD_W-1:0] sh_new;
	logic [LEAD_W-1:0] sh_tail;
	logic [DIGIT_W-1:0] win_new;
	logic [DIGIT_W-1:0] spill;
	logic [DIGIT_W-1:0] part;

	always_comb begin
		lb_new  = bit_len(digit);
		sh_new  = FULL_DIGIT - lb_new;
		win_new = digit << sh_new[5:0];
		sh_tail = FULL_DIGIT - cur_q.lead_bits;
		spill   = digit << sh_tail[5:0];
		part    = digit >> cur_q.lead_bits[5:0];
		nxt     = cur_q;
		priority if (first_digit) begin
			nxt.value_sign  = negative;
			nxt.digits_seen = COUNT_W'(1);
			nxt.lead_bits   = lb_new;
			nxt.top_window  = win_new;
			nxt.sticky_flag = 1'b0;
		end else if (cur_q.digits_seen == '0) begin
			nxt = cur_q;
		end else if (cur_q.lead_bits == '0) begin
			// leading zero digits are skipped
			nxt.lead_bits   = lb_new;
			nxt.top_window  = win_new;
			nxt.sticky_flag = 1'b0;
		end else begin
			if (cur_q.digits_seen == COUNT_W'(1) && cur_q.lead_bits < FULL_DIGIT) begin
				nxt.top_window = cur_q.top_window | part;
				if (spill != '0) begin
					nxt.sticky_flag = 1'b1;
				end
			end else if (digit != '0) begin
				nxt.sticky_flag = 1'b1;
			end
			if (cur_q.digits_seen < DIGITS_SAT) begin
				nxt.digits_seen = cur_q.digits_seen + COUNT_W'(1);
			end
		end
	end

	assign snap       = nxt;
	assign snap_valid = take && last_digit && (first_digit || cur_q.digits_seen != '0);
	assign active     = (cur_q.digits_seen != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (take) begin
			if (last_digit) begin
				cur_q <= '0;
			end else begin
				cur_q <= nxt;
			end
		end
	end

endmodule

`default_nettype wire

/* design/b2d_round.sv */
// Round-to-nearest-even of the 64-bit window and binary64 packing.
// Depends on b2d_pkg.
`default_nettype none

module b2d_round
	import b2d_pkg::*;
(
	input  wire b2d_snap_t       snap,
	output logic [DIGIT_W-1:0]   double_bits,
	output logic                 overflowed
);

	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] total_r;
	logic [TOTAL_W-1:0] exp_wide;
	logic [52:0]        mant;
	logic [10:0]        rest;
	logic               up;
	logic [53:0]        mant_r;
	logic [51:0]        frac;

	always_comb begin
		total    = TOTAL_W'({snap.digits_seen - COUNT_W'(1), 6'd0}) + TOTAL_W'(snap.lead_bits);
		mant     = snap.top_window[63:11];
		rest     = snap.top_window[10:0];
		up       = (rest > ROUND_HALF) ||
		           (rest == ROUND_HALF && (snap.sticky_flag || mant[0]));
		mant_r   = up ? ({1'b0, mant} + 54'd1) : {1'b0, mant};
		// carry out of the mantissa: value is now an exact power of two
		total_r  = total + TOTAL_W'(mant_r[53]);
		frac     = mant_r[53] ? 52'd0 : mant_r[51:0];
		exp_wide = total_r + EXP_OFFSET;
		if (snap.lead_bits == '0) begin
			double_bits = '0;
			overflowed  = 1'b0;
		end else if (total_r > MAX_BITS) begin
			double_bits = {snap.value_sign, EXP_ALL_ONES, 52'd0};
			overflowed  = 1'b1;
		end else begin
			double_bits = {snap.value_sign, exp_wide[10:0], frac};
			overflowed  = 1'b0;
		end
	end

endmodule

`default_nettype wire

/* design/bigint_to_double_rne_core.sv */
// Big integer (64-bit digits, MSD first) to IEEE-754 double, round nearest even.
// Throughput: one digit per cycle; digits are never stalled except by a full result path.
// Result path: after the last digit is accepted, the value is registered in the snapshot
// register, then in the output register, where double_valid rises.
// Reset: arst_n clears the accumulator and both valid bits asynchronously.
// Depends on b2d_pkg, b2d_accum, b2d_round and the assertion macro header.
`default_nettype none

`include "bigint_to_double_rne_core_macros.svh"

module bigint_to_double_rne_core
	import b2d_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// digit channel
	input  wire logic               digit_valid,
	output logic                    digit_stall,
	input  wire logic [DIGIT_W-1:0] digit,
	input  wire logic               negative,
	input  wire logic               first_digit,
	input  wire logic               last_digit,
	// result channel
	output logic                    double_valid,
	input  wire logic               double_stall,
	output logic [DIGIT_W-1:0]      double_bits,
	output logic                    overflowed
);

	// Handshake bookkeeping
	logic               take;       // digit transaction this cycle
	logic               out_adv;    // output register free or draining
	logic               s1_free;    // snapshot register can load

	// Accumulator outputs
	logic               snap_valid;
	b2d_snap_t          snap;
	logic               active;

	// Snapshot stage: the finished value, waiting for rounding
	logic               valid_s1;
	b2d_snap_t          snap_s1;

	// Rounding result, registered into the output stage
	logic [DIGIT_W-1:0] bits_rnd;
	logic               ovf_rnd;
	logic               valid_s2;
	logic [DIGIT_W-1:0] bits_s2;
	logic               ovf_s2;

	assign out_adv     = !valid_s2 || !double_stall;
	assign s1_free     = !valid_s1 || out_adv;
	// Only a held snapshot behind a stalled output blocks new digits.
	assign digit_stall = !s1_free;
	assign take        = digit_valid && !digit_stall;

	b2d_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.digit       (digit),
		.negative    (negative),
		.first_digit (first_digit),
		.last_digit  (last_digit),
		.snap_valid  (snap_valid),
		.snap        (snap),
		.active      (active)
	);

	// Snapshot register: valid bit reset, payload loaded on a finished value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && snap_valid) begin
			snap_s1 <= snap;
		end
	end

	b2d_round u_round (
		.snap        (snap_s1),
		.double_bits (bits_rnd),
		.overflowed  (ovf_rnd)
	);

	// Output register: holds while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			bits_s2 <= bits_rnd;
			ovf_s2  <= ovf_rnd;
		end
	end

	assign double_valid = valid_s2;
	assign double_bits  = bits_s2;
	assign overflowed   = ovf_s2;

	// Overflow always comes out as a clean infinity.
	`B2D_ASSERT_NOW(a_ovf_is_inf, double_valid && overflowed, double_bits[62:52] == EXP_ALL_ONES && double_bits[51:0] == 52'd0, "overflow result is not infinity")

	// Zero results never carry the sign.
	`B2D_ASSERT_NOW(a_zero_positive, double_valid && double_bits[62:0] == 63'd0, !double_bits[63], "negative zero produced")

	// A lone zero digit reaches the snapshot stage as a zero value.
	`B2D_ASSERT_NEXT(a_lone_zero, take && first_digit && last_digit && digit == 64'd0, valid_s1 && snap_s1.lead_bits == 7'd0, "lone zero digit lost")

	// A final digit with no value started produces nothing.
	`B2D_ASSERT_NEXT(a_orphan_drop, take && !first_digit && last_digit && !active, !valid_s1, "orphan digit produced a result")

	// Every last digit leaves the accumulator idle.
	`B2D_ASSERT_NEXT(a_clear_after_last, take && last_digit, !active, "accumulator not cleared after result")

endmodule

`default_nettype wire

/* tb/sv/tb_bigint_to_double_rne_core.sv */
// Self-checking testbench for bigint_to_double_rne_core: streams of 64-bit digits
// are converted by an in-bench rounding predictor and compared with the block's doubles.
// Depends on b2d_pkg and the bigint_to_double_rne_core RTL.
`default_nettype none

module tb_bigint_to_double_rne_core;
	import b2d_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Quiet limit: the longest honest silence is the long receiver hold (HOLD_CYCLES)
	// plus random gaps, so QUIET_LIMIT is set well above it and only trips on a real hang.
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned PHASE_ITEMS  = 120;

	// Rounding constants of binary64
	localparam logic [10:0] INF_EXP    = 11'h7ff;
	localparam logic [10:0] HALF_ULP   = 11'h400;
	localparam int unsigned WIDEST     = 1024;
	localparam int unsigned EXP_BIAS_M = 1022;
	localparam logic [4:0]  COUNT_CAP  = 5'd31;

	typedef struct {
		logic [DIGIT_W-1:0] digit;
		logic               neg;
		logic               first;
		logic               last;
	} digit_txn_t;

	typedef struct {
		logic [DIGIT_W-1:0] bits;
		logic               ovf;
	} dbl_result_t;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               digit_valid = 1'b0;
	logic               digit_stall;
	logic [DIGIT_W-1:0] digit       = '0;
	logic               negative    = 1'b0;
	logic               first_digit = 1'b0;
	logic               last_digit  = 1'b0;
	logic               double_valid;
	logic               double_stall = 1'b0;
	logic [DIGIT_W-1:0] double_bits;
	logic               overflowed;

	// Stimulus and expectation stores
	digit_txn_t  pending_digits[$];
	dbl_result_t expected_doubles[$];

	// Idle knobs, changed by the sequencer at negedge only
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_req       = 0;
	int unsigned fail_count     = 0;
	int unsigned queued_items   = 0;

	// Predictor copy of the accumulator
	logic               acc_sign;
	logic [4:0]         acc_count;
	logic [6:0]         acc_lead;
	logic [DIGIT_W-1:0] acc_window;
	logic               acc_sticky;

	bigint_to_double_rne_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.digit_valid  (digit_valid),
		.digit_stall  (digit_stall),
		.digit        (digit),
		.negative     (negative),
		.first_digit  (first_digit),
		.last_digit   (last_digit),
		.double_valid (double_valid),
		.double_stall (double_stall),
		.double_bits  (double_bits),
		.overflowed   (overflowed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Number of significant bits in a word, scanning from the top.
	function automatic int unsigned sig_bits(input logic [DIGIT_W-1:0] v);
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				return i + 1;
			end
		end
		return 0;
	endfunction

	// Leading digit: left-align it in the window (zero for a zero digit), restart the sticky bit.
	task automatic take_leading(input logic [DIGIT_W-1:0] d);
		acc_lead   = 7'(sig_bits(d));
		acc_window = (acc_lead != 0) ? (d << (DIGIT_W - acc_lead)) : '0;
		acc_sticky = 1'b0;
	endtask

	task automatic clear_accum();
		acc_sign   = 1'b0;
		acc_count  = '0;
		acc_lead   = '0;
		acc_window = '0;
		acc_sticky = 1'b0;
	endtask

	// Fold one accepted digit transaction into the accumulator; on the closing
	// digit round the window and queue the expected double.
	task automatic absorb_digit(input logic [DIGIT_W-1:0] d, input logic neg,
			input logic first, input logic last);
		logic [DIGIT_W-1:0] mant;
		logic [10:0]        rest;
		int unsigned        total;
		logic               rnd_inc;
		dbl_result_t        res;
		if (first) begin
			acc_sign  = neg;
			acc_count = 5'd1;
			take_leading(d);
		end else if (acc_count == 0) begin
			return;    // stray digit with no value open
		end else if (acc_lead == 0) begin
			take_leading(d);    // still skipping leading zero digits
		end else begin
			// Only the digit right after the leader can still fill the window.
			if (acc_count == 5'd1 && acc_lead < DIGIT_W) begin
				acc_window |= d >> acc_lead;
				if ((d << (DIGIT_W - acc_lead)) != 0) begin
					acc_sticky = 1'b1;
				end
			end else if (d != 0) begin
				acc_sticky = 1'b1;
			end
			if (acc_count < COUNT_CAP) begin
				acc_count++;
			end
		end
		if (!last) begin
			return;
		end
		res.ovf = 1'b0;
		if (acc_lead == 0) begin
			res.bits = '0;    // all-zero value is +0.0 regardless of sign
		end else begin
			total    = (int'(acc_count) - 1) * DIGIT_W + int'(acc_lead);
			mant     = acc_window >> 11;
			rest     = acc_window[10:0];
			rnd_inc  = (rest > HALF_ULP) || (rest == HALF_ULP && (acc_sticky || mant[0]));
			if (rnd_inc) begin
				mant++;
				if (mant == (64'd1 << 53)) begin
					mant >>= 1;    // mantissa carry-out bumps the exponent
					total++;
				end
			end
			if (total > WIDEST) begin
				res.bits = {acc_sign, INF_EXP, 52'd0};
				res.ovf  = 1'b1;
			end else begin
				res.bits = {acc_sign, 11'(total + EXP_BIAS_M), mant[51:0]};
			end
		end
		expected_doubles.push_back(res);
		clear_accum();
	endtask

	// ------------------------------------------------------------------
	// Driver: presents queued digits, feeds the predictor on acceptance
	// ------------------------------------------------------------------
	always @(posedge clk) begin : digit_driver
		digit_txn_t nxt;
		if (arst_n) begin
			if (digit_valid && !digit_stall) begin
				absorb_digit(digit, negative, first_digit, last_digit);
			end
			// Payload only moves when the current transaction is gone or never was.
			if (!digit_valid || !digit_stall) begin
				if (pending_digits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_digits.pop_front();
					digit_valid <= 1'b1;
					digit       <= nxt.digit;
					negative    <= nxt.neg;
					first_digit <= nxt.first;
					last_digit  <= nxt.last;
				end else begin
					digit_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall: random back-pressure plus a long hold on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_stall
		int unsigned hold_seen;
		int unsigned hold_left;
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			double_stall <= 1'b1;
		end else begin
			double_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each result transaction against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		dbl_result_t want;
		if (arst_n && double_valid && !double_stall) begin
			if (expected_doubles.size() == 0) begin
				$error("unexpected result: double_bits %h overflowed %b",
					double_bits, overflowed);
				fail_count++;
			end else begin
				want = expected_doubles.pop_front();
				if (double_bits !== want.bits) begin
					$error("double_bits mismatch: expected %h, actual %h",
						want.bits, double_bits);
					fail_count++;
				end
				if (overflowed !== want.ovf) begin
					$error("overflowed mismatch: expected %b, actual %b",
						want.ovf, overflowed);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no transaction on either side is a hang
	// ------------------------------------------------------------------
	always @(posedge clk) begin : hang_watch
		int unsigned quiet;
		if (!arst_n || (digit_valid && !digit_stall) || (double_valid && !double_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_digit(input logic [DIGIT_W-1:0] d, input logic neg,
			input logic first, input logic last);
		digit_txn_t t;
		t.digit = d;
		t.neg   = neg;
		t.first = first;
		t.last  = last;
		pending_digits.push_back(t);
	endtask

	function automatic logic [DIGIT_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Leading digit of random length; long ones are biased toward exact ties
	// and near-ties in the bits that fall below the 53-bit mantissa.
	function automatic logic [DIGIT_W-1:0] make_leader();
		logic [DIGIT_W-1:0] d;
		int unsigned        len;
		int unsigned        k;
		len = $urandom_range(0, 1) ? DIGIT_W : $urandom_range(1, DIGIT_W);
		d   = rand_word();
		if (len < DIGIT_W) begin
			d &= (64'd1 << len) - 1;
		end
		d[len-1] = 1'b1;
		if (len > 53 && $urandom_range(0, 2) == 0) begin
			k = len - 53;
			d &= ~((64'd1 << k) - 1);
			if ($urandom_range(0, 1)) begin
				d[k-1] = 1'b1;                     // exactly half an ulp
			end else if (k > 1) begin
				d |= (64'd1 << (k - 1)) - 1;       // just under half
			end
		end
		return d;
	endfunction

	function automatic logic [DIGIT_W-1:0] make_tail_digit();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return 64'd1 << $urandom_range(0, 63);
			default: return rand_word();
		endcase
	endfunction

	// Mostly short values, some near the 1024-bit edge, a few past saturation.
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 90) return $urandom_range(4, 14);
		if (r < 97) return $urandom_range(15, 18);
		return $urandom_range(30, 34);
	endfunction

	// One well-formed value: optional leading zero digits, leader, tail digits.
	task automatic queue_value(input int unsigned n, input logic neg, input int unsigned zeros);
		push_digit(zeros > 0 ? 64'd0 : make_leader(), neg, 1'b1, n == 1 && zeros == 0);
		for (int unsigned i = 1; i < zeros; i++) begin
			push_digit('0, $urandom_range(0, 1), 1'b0, 1'b0);
		end
		if (zeros > 0) begin
			push_digit(make_leader(), $urandom_range(0, 1), 1'b0, n == 1);
		end
		for (int unsigned i = 1; i < n; i++) begin
			push_digit(make_tail_digit(), $urandom_range(0, 1), 1'b0, i == n - 1);
		end
		queued_items += n + zeros;
	endtask

	// Value built from a chosen leader and a repeated fill digit.
	task automatic queue_wide(input logic [DIGIT_W-1:0] lead, input logic [DIGIT_W-1:0] fill,
			input int unsigned n, input logic neg);
		push_digit(lead, neg, 1'b1, 1'b0);
		for (int unsigned i = 1; i < n; i++) begin
			push_digit(fill, neg, 1'b0, i == n - 1);
		end
		queued_items += n;
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned stop_at;
		int unsigned r;
		stop_at = queued_items + count;
		while (queued_items < stop_at) begin
			r = $urandom_range(99);
			if (r < 78) begin
				queue_value(pick_length(), $urandom_range(0, 1),
					($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
			end else if (r < 86) begin
				// zero value, lone or several zero digits
				queue_wide('0, '0, $urandom_range(1, 3), $urandom_range(0, 1));
				if (pending_digits[$].first) begin
					pending_digits[$].last = 1'b1;
				end
			end else if (r < 94) begin
				// broken value: opened, never closed, overtaken by the next start
				push_digit(make_leader(), $urandom_range(0, 1), 1'b1, 1'b0);
				push_digit(make_tail_digit(), $urandom_range(0, 1), 1'b0, 1'b0);
				queued_items += 2;
			end else begin
				// stray digit with no start; ignored when nothing is open
				push_digit(rand_word(), $urandom_range(0, 1), 1'b0, $urandom_range(0, 1));
			end
		end
	endtask

	// Sender pause: nothing left to send or in flight, every result back.
	task automatic wait_drained();
		while (pending_digits.size() != 0 || digit_valid || expected_doubles.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		clear_accum();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corner values, one transaction each unless noted
		set_idling(0, 0);
		push_digit(64'd0, 1'b1, 1'b1, 1'b1);                        // lone zero, negative -> +0
		push_digit(64'd1, 1'b0, 1'b1, 1'b1);                        // 1.0
		push_digit('1, 1'b1, 1'b1, 1'b1);                           // rounds up, mantissa carry
		push_digit((64'd1 << 53) | 64'd1, 1'b0, 1'b1, 1'b1);        // tie, even -> down
		push_digit((64'd1 << 53) | 64'd3, 1'b0, 1'b1, 1'b1);        // tie, odd -> up
		push_digit(64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1);      // top bit only
		push_digit((64'd1 << 53) | 64'd1, 1'b0, 1'b1, 1'b0);        // tie broken by sticky
		push_digit(64'd1, 1'b0, 1'b0, 1'b1);
		push_digit('1, 1'b0, 1'b1, 1'b0);                           // full-width leader
		push_digit(64'd0, 1'b1, 1'b0, 1'b1);
		push_digit(64'd0, 1'b1, 1'b1, 1'b0);                        // leading zero digits
		push_digit(64'd0, 1'b0, 1'b0, 1'b0);
		push_digit(64'd5, 1'b1, 1'b0, 1'b1);
		push_digit(64'd0, 1'b1, 1'b1, 1'b0);                        // all-zero, negative -> +0
		push_digit(64'd0, 1'b1, 1'b0, 1'b1);
		push_digit(64'hdead_beef_0bad_f00d, 1'b1, 1'b0, 1'b1);      // stray digit, no result
		push_digit(64'd7, 1'b0, 1'b1, 1'b0);                        // restart abandons 7
		push_digit(64'd3, 1'b1, 1'b1, 1'b1);
		push_digit(64'd1, 1'b0, 1'b1, 1'b0);                        // one-bit leader, window filled
		push_digit('1, 1'b0, 1'b0, 1'b1);                           // from the next digit
		queued_items += 20;
		wait_drained();

		// No idling, plus the exponent edges: max finite, 2^1023, carry into
		// infinity, one digit past the range, saturated count.
		queue_wide(64'hffff_ffff_ffff_f800, '0, 16, 1'b0);
		queue_wide(64'hffff_ffff_ffff_f800, 64'd1, 16, 1'b1);
		queue_wide(64'h8000_0000_0000_0000, '0, 16, 1'b1);
		queue_wide('1, '1, 16, 1'b0);
		queue_wide(64'd1, '0, 17, 1'b1);
		queue_wide(64'd1, '0, 34, 1'b0);
		queue_random(PHASE_ITEMS);
		wait_drained();

		set_idling(54, 0);
		queue_random(PHASE_ITEMS);
		wait_drained();

		set_idling(0, 54);
		queue_random(PHASE_ITEMS);
		wait_drained();

		set_idling(19, 19);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// Back-pressure: receiver holds off while short values keep coming,
		// so the result path fills and the digit side must stall.
		set_idling(0, 0);
		hold_req++;
		for (int i = 0; i < 80; i++) begin
			queue_value(1, $urandom_range(0, 1), 0);
		end
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/b2d_pkg.sv
design/b2d_accum.sv
design/b2d_round.sv
design/bigint_to_double_rne_core.sv
tb/sv/tb_bigint_to_double_rne_core.sv
